// ----- rtl/ibas_pkg.sv -----
// Package for the infrared burst attack scorer.
// Holds the CSR indexes, alert state codes and divider request/response types.
// No dependencies.
package ibas_pkg;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BUCKET_MS      = 3'd0,
      CSR_WINDOW_BUCKETS = 3'd1,
      CSR_RATE_SATURATE  = 3'd2,
      CSR_ENTER_COUNT    = 3'd3,
      CSR_HOLD_MS        = 3'd4,
      CSR_SUSPECT_LEVEL  = 3'd5,
      CSR_ALERT_LEVEL    = 3'd6,
      CSR_DISTINCT_MIN   = 3'd7
   } csr_idx_type;

   typedef enum logic [1:0] {
      MODE_NORMAL  = 2'd0,
      MODE_SUSPECT = 2'd1,
      MODE_ALERT   = 2'd2
   } mode_type;

   typedef struct packed {
      logic        start;
      logic [31:0] num;
      logic [31:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quo;
   } div_rsp_type;

endpackage

// ----- rtl/ibas_div.sv -----
// Shared restoring divider for the scorer, one quotient bit per cycle.
// Depends on ibas_pkg.
module ibas_div
   import ibas_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [31:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[31:0], quo_ff[31]};
      if (req.start) begin
         quo_in  = req.num;
         rem_in  = '0;
         den_in  = req.den;
         cnt_in  = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule

// ----- rtl/ir_burst_attack_scorer.sv -----
// Scorer top level: bucket history, protocol ring and sequencer over ibas_div; uses ibas_pkg.
// Per poll: advance the buckets it crosses, count it into the head bucket, sum the window,
// count distinct ring protocols, run three divides on ibas_div, then score and register.
// Throughput: one item at a time; a result held by rsp_tready stalls the next one in scoring.
// After reset the history is swept clear with req_tready low.
// Reset is synchronous, active high, and restores register defaults.
module ir_burst_attack_scorer
   import ibas_pkg::*;
#(
   parameter int HISTORY_BUCKETS = 40,
   parameter int RING_DEPTH = 8
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // elapsed_ms[9:0], event_present[10], event_valid[11], protocol_code[19:12]
   input  logic [23:0]           req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // score[6:0], alert_state[8:7], events_per_sec[20:9], valid_pct[27:21],
   // distinct_protocols[31:28], valid_burst_flag[32], jammer_flag[33]
   output logic [39:0]           rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int HW = (HISTORY_BUCKETS > 1) ? $clog2(HISTORY_BUCKETS) : 1;
   localparam int RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int FW = $clog2(RING_DEPTH + 1);
   localparam logic [HW-1:0] HLAST = HW'(HISTORY_BUCKETS - 1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_ADV, S_LOAD, S_COUNT, S_SUM, S_DIST, S_EPS, S_PCT, S_W1,
      S_SCORE, S_OUT
   } state_type;

   state_type state_ff;

   logic [9:0]  bucket_ms_ff;
   logic [5:0]  window_ff;
   logic [7:0]  rate_sat_ff;
   logic [3:0]  enter_ff;
   logic [15:0] hold_ff;
   logic [6:0]  suspect_ff, alert_ff;
   logic [3:0]  dmin_ff;

   logic [7:0] ev_mem [HISTORY_BUCKETS];
   logic [7:0] fl_mem [HISTORY_BUCKETS];
   logic [7:0] proto_mem [RING_DEPTH];

   logic [HW-1:0] head_ff, addr_ff;
   logic          lag_ff;
   logic [10:0]   ms_ff;
   logic [RW-1:0] wpos_ff;
   logic [FW-1:0] fill_ff;
   logic [1:0]    mode_ff;
   logic [3:0]    streak_ff;
   logic [16:0]   since_ff;
   logic [9:0]    elapsed_ff;
   logic          present_ff, valid_ff;
   logic [7:0]    proto_ff;
   logic [5:0]    cnt_ff;
   logic [13:0]   total_ff, fails_ff;
   logic [FW-1:0] i_ff, j_ff;
   logic          dup_ff;
   logic [3:0]    dist_ff;
   logic [11:0]   eps_ff;
   logic [6:0]    pct_ff;
   logic [6:0]    w1_ff;
   logic [39:0]   rsp_ff;
   logic          rsp_valid_ff;
   logic          div_wait_ff;
   logic [7:0]    rd_ev_ff, rd_fl_ff;

   logic [9:0]  bm;
   logic [5:0]  win;
   logic [7:0]  rs;
   div_req_type dreq;
   div_rsp_type drsp;

   assign bm  = (bucket_ms_ff == '0) ? 10'd1 : bucket_ms_ff;
   assign win = (window_ff == '0) ? 6'd1 :
                (32'(window_ff) > HISTORY_BUCKETS) ? 6'(HISTORY_BUCKETS) : window_ff;
   assign rs  = (rate_sat_ff == '0) ? 8'd1 : rate_sat_ff;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   ibas_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   always_comb begin
      dreq.start = 1'b0;
      dreq.num   = '0;
      dreq.den   = 32'd1;
      if (!div_wait_ff) begin
         unique case (state_ff)
            S_EPS: begin
               dreq.start = 1'b1;
               dreq.num   = 32'(total_ff) * 32'd1000;
               dreq.den   = 32'(win) * 32'(bm);
            end
            S_PCT: begin
               dreq.start = 1'b1;
               dreq.num   = 32'((fails_ff <= total_ff) ? total_ff - fails_ff : 14'd0)
                            * 32'd100;
               dreq.den   = 32'(total_ff);
            end
            S_W1: begin
               dreq.start = 1'b1;
               dreq.num   = 32'(eps_ff) * 32'd60;
               dreq.den   = 32'(rs);
            end
            default: ;
         endcase
      end
   end

   logic [6:0]  sc;
   logic        burst, jam;
   logic        nz;
   logic [7:0]  sum7;
   logic [6:0]  w2;
   logic [16:0] since_nx;
   logic [3:0]  streak_nx;
   logic [1:0]  mode_nx;
   always_comb begin
      nz    = (total_ff != '0);
      burst = (pct_ff >= 7'd70) && (dist_ff >= dmin_ff);
      jam   = !burst && (pct_ff <= 7'd30);
      w2    = (burst || jam) ? 7'd40 : 7'd15;
      sum7  = {1'b0, w1_ff} + {1'b0, w2};
      sc    = !nz ? 7'd0 : (sum7 > 8'd100) ? 7'd100 : sum7[6:0];
      since_nx = since_ff + 17'(elapsed_ff);
      if (since_nx > 17'hFFFF) since_nx = 17'hFFFF;
      if (sc >= suspect_ff) since_nx = '0;
      streak_nx = streak_ff;
      mode_nx   = mode_ff;
      if (sc >= alert_ff) begin
         if (streak_ff < 4'd15) streak_nx = streak_ff + 4'd1;
         if (streak_nx >= enter_ff) mode_nx = MODE_ALERT;
      end else begin
         streak_nx = '0;
         if (mode_ff != MODE_ALERT && sc >= suspect_ff) mode_nx = MODE_SUSPECT;
      end
      if (since_nx > {1'b0, hold_ff}) mode_nx = MODE_NORMAL;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_ms_ff <= 10'd200;
         window_ff    <= 6'd10;
         rate_sat_ff  <= 8'd6;
         enter_ff     <= 4'd2;
         hold_ff      <= 16'd4000;
         suspect_ff   <= 7'd40;
         alert_ff     <= 7'd70;
         dmin_ff      <= 4'd3;
      end else if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_BUCKET_MS:      bucket_ms_ff <= csr_data[9:0];
            CSR_WINDOW_BUCKETS: window_ff    <= csr_data[5:0];
            CSR_RATE_SATURATE:  rate_sat_ff  <= csr_data[7:0];
            CSR_ENTER_COUNT:    enter_ff     <= csr_data[3:0];
            CSR_HOLD_MS:        hold_ff      <= csr_data;
            CSR_SUSPECT_LEVEL:  suspect_ff   <= csr_data[6:0];
            CSR_ALERT_LEVEL:    alert_ff     <= csr_data[6:0];
            CSR_DISTINCT_MIN:   dmin_ff      <= csr_data[3:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rd_ev_ff <= ev_mem[addr_ff];
      rd_fl_ff <= fl_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         addr_ff      <= '0;
         head_ff      <= '0;
         ms_ff        <= '0;
         wpos_ff      <= '0;
         fill_ff      <= '0;
         mode_ff      <= MODE_NORMAL;
         streak_ff    <= '0;
         since_ff     <= 17'hFFFF;
         rsp_valid_ff <= 1'b0;
         div_wait_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               ev_mem[addr_ff] <= '0;
               fl_mem[addr_ff] <= '0;
               addr_ff <= (addr_ff == HLAST) ? '0 : addr_ff + 1'b1;
               if (addr_ff == HLAST) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  elapsed_ff <= req_tdata[9:0];
                  present_ff <= req_tdata[10];
                  valid_ff   <= req_tdata[11];
                  proto_ff   <= req_tdata[19:12];
                  ms_ff      <= ms_ff + 11'(req_tdata[9:0]);
                  state_ff   <= S_ADV;
               end
            end
            S_ADV: begin
               if (ms_ff >= 11'(bm)) begin
                  head_ff <= (head_ff == HLAST) ? '0 : head_ff + 1'b1;
                  ev_mem[(head_ff == HLAST) ? '0 : head_ff + 1'b1] <= '0;
                  fl_mem[(head_ff == HLAST) ? '0 : head_ff + 1'b1] <= '0;
                  ms_ff <= ms_ff - 11'(bm);
               end else begin
                  addr_ff  <= head_ff;
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               state_ff <= S_COUNT;
            end
            S_COUNT: begin
               if (present_ff) begin
                  if (rd_ev_ff != 8'hFF) ev_mem[head_ff] <= rd_ev_ff + 8'd1;
                  if (!valid_ff && rd_fl_ff != 8'hFF) fl_mem[head_ff] <= rd_fl_ff + 8'd1;
                  if (valid_ff) begin
                     proto_mem[wpos_ff] <= proto_ff;
                     wpos_ff <= (32'(wpos_ff) == RING_DEPTH - 1) ? '0 : wpos_ff + 1'b1;
                     if (32'(fill_ff) < RING_DEPTH) fill_ff <= fill_ff + 1'b1;
                  end
               end
               total_ff <= '0;
               fails_ff <= '0;
               cnt_ff   <= '0;
               lag_ff   <= 1'b0;
               addr_ff  <= head_ff;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               addr_ff <= (addr_ff == '0) ? HLAST : addr_ff - 1'b1;
               lag_ff  <= 1'b1;
               if (lag_ff) begin
                  total_ff <= total_ff + 14'(rd_ev_ff);
                  fails_ff <= fails_ff + 14'(rd_fl_ff);
                  cnt_ff   <= cnt_ff + 6'd1;
                  if (cnt_ff + 6'd1 == win) begin
                     i_ff <= '0;
                     j_ff <= '0;
                     dup_ff <= 1'b0;
                     dist_ff <= '0;
                     state_ff <= S_DIST;
                  end
               end
            end
            S_DIST: begin
               if (i_ff >= fill_ff) begin
                  state_ff <= S_EPS;
               end else if (j_ff == i_ff) begin
                  if (!dup_ff) dist_ff <= dist_ff + 4'd1;
                  i_ff <= i_ff + 1'b1;
                  j_ff <= '0;
                  dup_ff <= 1'b0;
               end else begin
                  if (proto_mem[RW'(j_ff)] == proto_mem[RW'(i_ff)]) dup_ff <= 1'b1;
                  j_ff <= j_ff + 1'b1;
               end
            end
            S_EPS: begin
               if (!div_wait_ff) div_wait_ff <= 1'b1;
               else if (drsp.done) begin
                  div_wait_ff <= 1'b0;
                  eps_ff <= (drsp.quo > 32'd2550) ? 12'd2550 : drsp.quo[11:0];
                  state_ff <= S_PCT;
               end
            end
            S_PCT: begin
               if (!div_wait_ff) div_wait_ff <= 1'b1;
               else if (drsp.done) begin
                  div_wait_ff <= 1'b0;
                  pct_ff <= drsp.quo[6:0];
                  state_ff <= S_W1;
               end
            end
            S_W1: begin
               if (!div_wait_ff) div_wait_ff <= 1'b1;
               else if (drsp.done) begin
                  div_wait_ff <= 1'b0;
                  w1_ff <= (drsp.quo > 32'd60) ? 7'd60 : drsp.quo[6:0];
                  state_ff <= S_SCORE;
               end
            end
            S_SCORE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  since_ff  <= since_nx;
                  streak_ff <= streak_nx;
                  mode_ff   <= mode_nx;
                  rsp_ff    <= {6'd0, nz & jam, nz & burst,
                                nz ? dist_ff : 4'd0,
                                nz ? pct_ff : 7'd0,
                                nz ? eps_ff : 12'd0,
                                mode_nx, sc};
                  state_ff  <= S_OUT;
               end
            end
            S_OUT: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ----- verif/ibas_checker.sv -----
`timescale 1ns / 1ps
// Checker for the infrared burst attack scorer: watches the poll, result and csr channels,
// predicts each result from its own copy of history, ring and alert state, and counts mismatches.
// Depends on ibas_pkg.
module ibas_checker
   import ibas_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [23:0]           req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [39:0]           rsp_tdata,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    fail_count,
   output int                    pending
);
   localparam int NB = 40;
   localparam int NR = 8;

   typedef struct packed {
      logic       jam;
      logic       burst;
      logic [3:0] distinct;
      logic [6:0] pct;
      logic [11:0] eps;
      logic [1:0] mode;
      logic [6:0] score;
   } score_rec_type;

   logic [9:0]  r_bucket_ms;
   logic [5:0]  r_window;
   logic [7:0]  r_rate_sat;
   logic [3:0]  r_enter;
   logic [15:0] r_hold;
   logic [6:0]  r_suspect;
   logic [6:0]  r_alert;
   logic [3:0]  r_distinct_min;

   int unsigned ev_cnt [NB];
   int unsigned fail_cnt [NB];
   int unsigned head, ms_acc, wr_pos, fill, streak, quiet_ms;
   logic [7:0]  protos [NR];
   mode_type    mode;
   score_rec_type expected_q [$];

   assign pending = expected_q.size();

   task automatic report(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic score_rec_type score_poll(input logic [23:0] d);
      int unsigned el, bm, win, rs, total, fails, eps, pct, distinct, w1, w2, sc, idx;
      logic present, valid, dup;
      score_rec_type r;
      el = 32'(d[9:0]);
      present = d[10];
      valid = d[11];
      bm = (r_bucket_ms == 0) ? 1 : 32'(r_bucket_ms);
      win = (r_window == 0) ? 1 : 32'(r_window);
      if (win > NB) win = NB;
      rs = (r_rate_sat == 0) ? 1 : 32'(r_rate_sat);
      total = 0; fails = 0; eps = 0; pct = 0; distinct = 0; sc = 0;
      r = '0;
      ms_acc += el;
      while (ms_acc >= bm) begin
         head = (head + 1) % NB;
         ev_cnt[head] = 0;
         fail_cnt[head] = 0;
         ms_acc -= bm;
      end
      if (present) begin
         if (ev_cnt[head] < 255) ev_cnt[head]++;
         if (!valid && fail_cnt[head] < 255) fail_cnt[head]++;
         if (valid) begin
            protos[wr_pos] = d[19:12];
            wr_pos = (wr_pos + 1) % NR;
            if (fill < NR) fill++;
         end
      end
      for (int i = 0; i < win; i++) begin
         idx = (head + NB - i) % NB;
         total += ev_cnt[idx];
         fails += fail_cnt[idx];
      end
      if (total != 0) begin
         eps = total * 1000 / (win * bm);
         if (eps > 2550) eps = 2550;
         pct = ((fails <= total) ? total - fails : 0) * 100 / total;
         for (int i = 0; i < fill; i++) begin
            dup = 0;
            for (int j = 0; j < i; j++)
               if (protos[j] == protos[i]) dup = 1;
            if (!dup) distinct++;
         end
         w1 = eps * 60 / rs;
         if (w1 > 60) w1 = 60;
         if (pct >= 70 && distinct >= r_distinct_min) begin
            w2 = 40; r.burst = 1;
         end else if (pct <= 30) begin
            w2 = 40; r.jam = 1;
         end else begin
            w2 = 15;
         end
         sc = w1 + w2;
         if (sc > 100) sc = 100;
      end
      quiet_ms += el;
      if (quiet_ms > 65535) quiet_ms = 65535;
      if (sc >= r_suspect) quiet_ms = 0;
      if (sc >= r_alert) begin
         if (streak < 15) streak++;
         if (streak >= r_enter) mode = MODE_ALERT;
      end else begin
         streak = 0;
         if (mode != MODE_ALERT && sc >= r_suspect) mode = MODE_SUSPECT;
      end
      if (quiet_ms > r_hold) mode = MODE_NORMAL;
      r.score = 7'(sc);
      r.mode = mode;
      r.eps = 12'(eps);
      r.pct = 7'(pct);
      r.distinct = 4'(distinct);
      return r;
   endfunction

   always @(posedge clock) begin
      score_rec_type got, want;
      if (reset) begin
         r_bucket_ms <= 200; r_window <= 10; r_rate_sat <= 6; r_enter <= 2;
         r_hold <= 4000; r_suspect <= 40; r_alert <= 70; r_distinct_min <= 3;
         for (int i = 0; i < NB; i++) begin
            ev_cnt[i] = 0;
            fail_cnt[i] = 0;
         end
         for (int i = 0; i < NR; i++) protos[i] = '0;
         head = 0; ms_acc = 0; wr_pos = 0; fill = 0; streak = 0; quiet_ms = 65535;
         mode = MODE_NORMAL;
         fail_count = 0;
         expected_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_idx_type'(csr_index))
               CSR_BUCKET_MS:      r_bucket_ms <= csr_data[9:0];
               CSR_WINDOW_BUCKETS: r_window <= csr_data[5:0];
               CSR_RATE_SATURATE:  r_rate_sat <= csr_data[7:0];
               CSR_ENTER_COUNT:    r_enter <= csr_data[3:0];
               CSR_HOLD_MS:        r_hold <= csr_data;
               CSR_SUSPECT_LEVEL:  r_suspect <= csr_data[6:0];
               CSR_ALERT_LEVEL:    r_alert <= csr_data[6:0];
               CSR_DISTINCT_MIN:   r_distinct_min <= csr_data[3:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[33:0];
            if (expected_q.size() == 0) begin
               report("unexpected item", 0, 0);
            end else begin
               want = expected_q.pop_front();
               if (got.score != want.score) report("score", got.score, want.score);
               if (got.mode != want.mode) report("alert_state", got.mode, want.mode);
               if (got.eps != want.eps) report("events_per_sec", got.eps, want.eps);
               if (got.pct != want.pct) report("valid_pct", got.pct, want.pct);
               if (got.distinct != want.distinct)
                  report("distinct_protocols", got.distinct, want.distinct);
               if (got.burst != want.burst) report("valid_burst_flag", got.burst, want.burst);
               if (got.jam != want.jam) report("jammer_flag", got.jam, want.jam);
            end
            if (rsp_tdata[39:34] != 0) report("padding", rsp_tdata[39:34], 0);
         end
         if (req_tvalid && req_tready) expected_q.push_back(score_poll(req_tdata));
      end
   end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Top of the scorer testbench: clock, reset, poll stimulus across register settings,
// random back-pressure and the verdict. Depends on ibas_pkg, ibas_checker and the block.
module testbench;
   import ibas_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [23:0]           req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [39:0]           rsp_tdata;
   logic                  csr_valid = 0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   int                    fail_count, pending, idle_cycles;
   logic                  stall_on = 1;

   always #4 clock = ~clock;

   ir_burst_attack_scorer dut (.*);

   ibas_checker checker_i (.*);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Result side: a random stall before each item, or none at all in quiet phases.
   initial begin
      int gap;
      @(posedge clock iff !reset);
      forever begin
         gap = stall_on ? $urandom_range(0, 7) : 0;
         if (gap != 0) begin
            rsp_tready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock iff rsp_tvalid);
      end
   end

   task automatic write_reg(input csr_idx_type idx, input int value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= 16'(value);
      @(posedge clock iff csr_ready);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic send_poll(input int el, input bit pres, input bit vld, input int proto);
      int gap;
      gap = stall_on ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {4'b0, proto[7:0], vld, pres, el[9:0]};
      @(posedge clock iff req_tready);
   endtask

   task automatic drain;
      req_tvalid <= 0;
      @(posedge clock iff pending == 0);
      repeat (300) @(posedge clock);
   endtask

   // Well-formed traffic: bursts of frames on a few protocols at short poll gaps.
   task automatic run_traffic(input int count);
      int kind, el, nproto;
      nproto = $urandom_range(1, 12);
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(0, 9);
         el = (kind == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 60);
         if (kind == 1) el = 1023;
         send_poll(el, $urandom_range(0, 5) != 0, $urandom_range(0, 2) != 0,
                   (kind == 2) ? $urandom_range(0, 255) : $urandom_range(0, nproto));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, empty window, ignored fields, hold expiry
      send_poll(0, 0, 0, 0);
      send_poll(0, 0, 1, 255);
      send_poll(1023, 0, 0, 0);
      send_poll(0, 1, 0, 255);
      send_poll(0, 1, 1, 0);
      send_poll(0, 1, 1, 255);
      for (int i = 0; i < 10; i++) send_poll(1, 1, 1, i);
      for (int i = 0; i < 6; i++) send_poll(0, 1, 0, 0);
      for (int i = 0; i < 6; i++) send_poll(1023, 0, 0, 0);
      drain();
      // saturating counters: long buckets that saturate at 255 frames
      write_reg(CSR_BUCKET_MS, 1000);
      write_reg(CSR_WINDOW_BUCKETS, 40);
      write_reg(CSR_RATE_SATURATE, 0);
      write_reg(CSR_ENTER_COUNT, 15);
      write_reg(CSR_HOLD_MS, 0);
      write_reg(CSR_SUSPECT_LEVEL, 0);
      write_reg(CSR_ALERT_LEVEL, 100);
      write_reg(CSR_DISTINCT_MIN, 8);
      stall_on = 0;
      for (int i = 0; i < 270; i++) send_poll(0, 1, i[0], i[3:0]);
      stall_on = 1;
      run_traffic(150);
      drain();
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_reg(CSR_BUCKET_MS, 0);
               write_reg(CSR_WINDOW_BUCKETS, 63);
               write_reg(CSR_RATE_SATURATE, 255);
               write_reg(CSR_ENTER_COUNT, 0);
               write_reg(CSR_HOLD_MS, 65535);
               write_reg(CSR_SUSPECT_LEVEL, 127);
               write_reg(CSR_ALERT_LEVEL, 0);
               write_reg(CSR_DISTINCT_MIN, 15);
            end
            1: begin
               write_reg(CSR_BUCKET_MS, 100);
               write_reg(CSR_WINDOW_BUCKETS, 0);
               write_reg(CSR_RATE_SATURATE, 1);
               write_reg(CSR_ENTER_COUNT, 1);
               write_reg(CSR_HOLD_MS, 60000);
               write_reg(CSR_SUSPECT_LEVEL, 100);
               write_reg(CSR_ALERT_LEVEL, 100);
               write_reg(CSR_DISTINCT_MIN, 0);
            end
            2: begin
               write_reg(CSR_BUCKET_MS, 200);
               write_reg(CSR_WINDOW_BUCKETS, 10);
               write_reg(CSR_RATE_SATURATE, 6);
               write_reg(CSR_ENTER_COUNT, 2);
               write_reg(CSR_HOLD_MS, 4000);
               write_reg(CSR_SUSPECT_LEVEL, 40);
               write_reg(CSR_ALERT_LEVEL, 70);
               write_reg(CSR_DISTINCT_MIN, 3);
            end
            default: begin
               write_reg(CSR_BUCKET_MS, $urandom_range(0, 1023));
               write_reg(CSR_WINDOW_BUCKETS, $urandom_range(0, 63));
               write_reg(CSR_RATE_SATURATE, $urandom_range(0, 255));
               write_reg(CSR_ENTER_COUNT, $urandom_range(0, 15));
               write_reg(CSR_HOLD_MS, $urandom_range(0, 65535));
               write_reg(CSR_SUSPECT_LEVEL, $urandom_range(0, 127));
               write_reg(CSR_ALERT_LEVEL, $urandom_range(0, 127));
               write_reg(CSR_DISTINCT_MIN, $urandom_range(0, 15));
            end
         endcase
         stall_on = (phase != 3);
         run_traffic(240);
         drain();
      end
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule

// ----- files.f -----
rtl/ibas_pkg.sv
rtl/ibas_div.sv
rtl/ir_burst_attack_scorer.sv
verif/ibas_checker.sv
verif/testbench.sv
